/* rtl/i2cmra_pkg.sv */
// Shared types and constants for the I2C master register-access engine.
package i2cmra_pkg;

    localparam int BufDepth = 256;
    localparam int BufAw    = 8;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_EDGE_HOLD = 2'd0,
        CFG_BIT_PHASE = 2'd1,
        CFG_ACK_TOUT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_TX_LOW    = 4'd3,
        PH_TX_HIGH   = 4'd4,
        PH_ACK_REL   = 4'd5,
        PH_ACK_WAIT  = 4'd6,
        PH_RX_LOW    = 4'd7,
        PH_RX_HIGH   = 4'd8,
        PH_MACK_LOW  = 4'd9,
        PH_MACK_HIGH = 4'd10,
        PH_STOP_A    = 4'd11,
        PH_STOP_B    = 4'd12
    } t_phase;

    // One tick after classification by the front part.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] wdata;
        logic       sda_in;
    } t_tick;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] rdata;
        logic       rdata_valid;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic [7:0] result_count;
    } t_res;

endpackage

/* rtl/i2cmra_queue.sv */
// Two-entry queue that holds ticks between the front and the bus engine.
module i2cmra_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2cmra_pkg::t_tick   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output i2cmra_pkg::t_tick   o_data
);
    import i2cmra_pkg::*;

    t_tick      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_ready)
        else $error("queue full but ready");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && r_cnt == 2'd1) |=> (r_cnt == 2'd2))
        else $error("queue count slip");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3))
        else $error("queue overflow");
endmodule

/* rtl/i2cmra_engine.sv */
// Bus engine: runs the I2C phases one tick at a time and forms the result.
module i2cmra_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  i2cmra_pkg::t_tick  i_tick,
    input  logic [7:0]         i_hold,
    input  logic [7:0]         i_half,
    input  logic [15:0]        i_tout,
    output logic               o_valid,
    input  logic               i_ready,
    output i2cmra_pkg::t_res   o_res
);
    import i2cmra_pkg::*;

    logic [7:0] r_buf [BufDepth];
    logic [7:0] r_buf_q;

    t_phase      r_ph, n_ph;
    logic [15:0] r_tc, n_tc;
    logic [3:0]  r_bc, n_bc;
    logic [7:0]  r_sh, n_sh;
    logic [7:0]  r_bi, n_bi;
    logic [7:0]  r_lp, n_lp;
    logic [7:0]  r_dev, n_dev, r_reg, n_reg, r_len, n_len;
    logic        r_rd, n_rd, r_fail, n_fail;
    logic [1:0]  r_stg, n_stg;
    logic        r_ov;
    t_res        r_res, n_res;

    // The next data byte is prefetched into r_buf_q: entry byte_index while
    // the register address is sent, entry byte_index + 1 while a data byte is.
    logic [BufAw-1:0] w_rd_addr;
    logic        w_fire, w_load, w_start;
    logic [7:0]  w_hold, w_half;
    logic [15:0] w_tc1;
    logic        w_hdone, w_bdone;
    t_phase      w_ph;
    logic        w_ack;

    assign o_ready = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign w_fire  = i_valid && o_ready;
    assign w_load  = w_fire && r_ph == PH_IDLE && i_tick.cmd == CMD_LOAD;
    assign w_start = w_fire && r_ph == PH_IDLE &&
                     (i_tick.cmd == CMD_WRITE || i_tick.cmd == CMD_READ);
    assign w_hold  = (i_hold == 8'd0) ? 8'd1 : i_hold;
    assign w_half  = (i_half == 8'd0) ? 8'd1 : i_half;
    assign w_rd_addr = n_bi + {7'd0, (n_stg == 2'd3)};

    always_ff @(posedge i_clk) begin
        if (w_load) r_buf[r_lp] <= i_tick.wdata;
        r_buf_q <= r_buf[w_rd_addr];
    end

    always_comb begin
        n_ph = r_ph; n_tc = r_tc; n_bc = r_bc; n_sh = r_sh; n_bi = r_bi;
        n_lp = r_lp; n_dev = r_dev; n_reg = r_reg; n_len = r_len;
        n_rd = r_rd; n_fail = r_fail; n_stg = r_stg;
        n_res = '0;
        w_ph = r_ph;
        w_tc1 = 16'd0; w_hdone = 1'b0; w_bdone = 1'b0; w_ack = 1'b0;
        if (w_fire) begin
            if (w_load) n_lp = r_lp + 8'd1;
            if (w_start) begin
                n_dev = i_tick.dev_addr; n_reg = i_tick.reg_addr;
                n_len = i_tick.byte_count;
                n_rd = (i_tick.cmd == CMD_READ);
                if (i_tick.cmd != CMD_READ) n_lp = 8'd0;
                n_bi = 8'd0; n_fail = 1'b0; n_sh = i_tick.dev_addr;
                n_stg = 2'd0; n_tc = 16'd0; w_ph = PH_START_A;
            end
            n_ph = w_ph;
            w_tc1 = n_tc + 16'd1;
            w_hdone = (w_tc1 >= {8'd0, w_hold});
            w_bdone = (w_tc1 >= {8'd0, w_half});
            w_ack = ({1'b0, r_bi} + 9'd1 >= {1'b0, r_len});
            n_res.scl_level = 1'b1;
            n_res.sda_level = 1'b1;
            unique case (w_ph)
                PH_START_B:   n_res.sda_level = 1'b0;
                PH_TX_LOW:  begin n_res.scl_level = 1'b0; n_res.sda_level = n_sh[7]; end
                PH_TX_HIGH:   n_res.sda_level = n_sh[7];
                PH_ACK_REL, PH_RX_LOW: n_res.scl_level = 1'b0;
                PH_MACK_LOW: begin n_res.scl_level = 1'b0; n_res.sda_level = w_ack; end
                PH_MACK_HIGH: n_res.sda_level = w_ack;
                PH_STOP_A:  begin n_res.scl_level = 1'b0; n_res.sda_level = 1'b0; end
                default: ;
            endcase
            unique case (w_ph)
                PH_START_A: begin
                    n_tc = w_tc1;
                    if (w_hdone) begin n_ph = PH_START_B; n_tc = '0; end
                end
                PH_START_B: begin
                    n_tc = w_tc1;
                    if (w_hdone) begin n_bc = '0; n_ph = PH_TX_LOW; n_tc = '0; end
                end
                PH_TX_LOW: begin
                    n_tc = w_tc1;
                    if (w_bdone) begin n_ph = PH_TX_HIGH; n_tc = '0; end
                end
                PH_TX_HIGH: begin
                    n_tc = w_tc1;
                    if (w_bdone) begin
                        n_sh = {r_sh[6:0], 1'b0};
                        n_bc = r_bc + 4'd1;
                        n_ph = (n_bc >= 4'd8) ? PH_ACK_REL : PH_TX_LOW;
                        n_tc = '0;
                    end
                end
                PH_ACK_REL: begin
                    n_tc = w_tc1;
                    if (w_bdone) begin n_ph = PH_ACK_WAIT; n_tc = '0; end
                end
                PH_ACK_WAIT: begin
                    if (!i_tick.sda_in) begin
                        n_tc = '0;
                        case (r_stg)
                            2'd0: begin
                                n_sh = r_reg; n_stg = 2'd1; n_bc = '0;
                                n_ph = PH_TX_LOW;
                            end
                            2'd1: begin
                                if (r_rd) begin
                                    n_sh = r_dev + 8'd1; n_stg = 2'd2;
                                    n_ph = PH_START_A;
                                end else if (r_bi < r_len) begin
                                    n_sh = r_buf_q; n_stg = 2'd3; n_bc = '0;
                                    n_ph = PH_TX_LOW;
                                end else n_ph = PH_STOP_A;
                            end
                            2'd2: begin
                                if (r_len == 8'd0) n_ph = PH_STOP_A;
                                else begin
                                    n_bc = '0; n_sh = '0; n_ph = PH_RX_LOW;
                                end
                            end
                            default: begin
                                n_bi = r_bi + 8'd1;
                                if (n_bi < r_len) begin
                                    n_sh = r_buf_q; n_stg = 2'd3; n_bc = '0;
                                    n_ph = PH_TX_LOW;
                                end else n_ph = PH_STOP_A;
                            end
                        endcase
                    end else if (r_tc >= i_tout) begin
                        n_fail = 1'b1; n_ph = PH_STOP_A; n_tc = '0;
                    end else n_tc = w_tc1;
                end
                PH_RX_LOW: begin
                    n_tc = w_tc1;
                    if (w_bdone) begin n_ph = PH_RX_HIGH; n_tc = '0; end
                end
                PH_RX_HIGH: begin
                    if (r_tc == 16'd0) begin
                        n_sh = {r_sh[6:0], i_tick.sda_in};
                        n_bc = r_bc + 4'd1;
                        if (n_bc >= 4'd8) begin
                            n_res.rdata = n_sh; n_res.rdata_valid = 1'b1;
                        end
                    end
                    n_tc = w_tc1;
                    if (w_bdone) begin
                        n_ph = (n_bc >= 4'd8) ? PH_MACK_LOW : PH_RX_LOW;
                        n_tc = '0;
                    end
                end
                PH_MACK_LOW: begin
                    n_tc = w_tc1;
                    if (w_bdone) begin n_ph = PH_MACK_HIGH; n_tc = '0; end
                end
                PH_MACK_HIGH: begin
                    n_tc = w_tc1;
                    if (w_bdone) begin
                        n_bi = r_bi + 8'd1; n_tc = '0;
                        if (n_bi < r_len) begin
                            n_bc = '0; n_sh = '0; n_ph = PH_RX_LOW;
                        end else n_ph = PH_STOP_A;
                    end
                end
                PH_STOP_A: begin
                    n_tc = w_tc1;
                    if (w_hdone) begin n_ph = PH_STOP_B; n_tc = '0; end
                end
                PH_STOP_B: begin
                    n_tc = w_tc1;
                    if (w_hdone) begin
                        n_res.done_res = 1'b1;
                        n_res.status = r_fail;
                        n_res.result_count = r_fail ? 8'd0 : (r_rd ? r_len : 8'd1);
                        n_ph = PH_IDLE; n_tc = '0;
                    end
                end
                default: ;
            endcase
            n_res.busy_res = (n_ph != PH_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_tc <= '0; r_bc <= '0; r_sh <= '0; r_bi <= '0;
            r_lp <= '0; r_dev <= '0; r_reg <= '0; r_len <= '0;
            r_rd <= 1'b0; r_fail <= 1'b0; r_stg <= '0; r_ov <= 1'b0;
        end else begin
            r_ph <= n_ph; r_tc <= n_tc; r_bc <= n_bc; r_sh <= n_sh; r_bi <= n_bi;
            r_lp <= n_lp; r_dev <= n_dev; r_reg <= n_reg; r_len <= n_len;
            r_rd <= n_rd; r_fail <= n_fail; r_stg <= n_stg;
            if (w_fire) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) r_res <= n_res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_IDLE) |-> (r_tc == 16'd0))
        else $error("tick counter not cleared in idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bc <= 4'd8))
        else $error("bit counter overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> $stable(r_res))
        else $error("stalled result changed");
endmodule

/* rtl/i2c_master_register_access_unit.sv */
// Top level of the I2C master register-access engine.
// A tick transfer's result passes through the two-entry input queue and then the
// result register before it is offered; a stall of the result output delays it.
// The engine takes one tick per cycle while the result output is not stalled.
// Reset (synchronous, active low) returns to idle, restores register defaults
// (hold 5, half phase 2, ACK timeout 250); the write buffer is not cleared.
module i2c_master_register_access_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_dev_addr,
    input  logic [7:0]  i_reg_addr,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_wdata,
    input  logic        i_sda_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic [7:0]  o_rdata,
    output logic        o_rdata_valid,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_status,
    output logic [7:0]  o_result_count
);
    import i2cmra_pkg::*;

    logic [7:0]  r_hold, r_half;
    logic [15:0] r_tout;
    t_tick       w_in, w_q;
    logic        w_qv, w_qr;
    t_res        w_res;

    // Configuration registers; a write takes effect at the edge that carries it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 8'd5;
            r_half <= 8'd2;
            r_tout <= 16'd250;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_EDGE_HOLD: r_hold <= i_cfg_data[7:0];
                CFG_BIT_PHASE: r_half <= i_cfg_data[7:0];
                CFG_ACK_TOUT:  r_tout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front part: packs the tick fields; the queue decouples the engine.
    always_comb begin
        w_in.cmd        = t_cmd'(i_cmd);
        w_in.dev_addr   = i_dev_addr;
        w_in.reg_addr   = i_reg_addr;
        w_in.byte_count = i_byte_count;
        w_in.wdata      = i_wdata;
        w_in.sda_in     = i_sda_in;
    end

    i2cmra_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_q)
    );

    i2cmra_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_tick(w_q),
        .i_hold(r_hold), .i_half(r_half), .i_tout(r_tout),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(w_res)
    );

    assign o_scl_level    = w_res.scl_level;
    assign o_sda_level    = w_res.sda_level;
    assign o_rdata        = w_res.rdata;
    assign o_rdata_valid  = w_res.rdata_valid;
    assign o_busy_res     = w_res.busy_res;
    assign o_done_res     = w_res.done_res;
    assign o_status       = w_res.status;
    assign o_result_count = w_res.result_count;
endmodule

/* bench/i2c_master_register_access_unit_test.sv */
// Testbench for the I2C master register-access engine with tick-level prediction.
module i2c_master_register_access_unit_test;
    import i2cmra_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_dev_addr;
    logic [7:0]  i_reg_addr;
    logic [7:0]  i_byte_count;
    logic [7:0]  i_wdata;
    logic        i_sda_in;
    logic        o_valid;
    logic        i_ready;
    logic        o_scl_level;
    logic        o_sda_level;
    logic [7:0]  o_rdata;
    logic        o_rdata_valid;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_status;
    logic [7:0]  o_result_count;

    i2c_master_register_access_unit uut (.*);

    // The bus engine as seen from outside: one expected result per tick transfer.
    class i2c_bus_scoreboard;
        logic [7:0]  edge_hold;
        logic [7:0]  bit_half;
        logic [15:0] ack_limit;
        t_phase      phase;
        int unsigned ticks;
        int unsigned bits;
        logic [7:0]  shreg;
        logic [7:0]  byte_idx;
        logic [7:0]  wbuf [BufDepth];
        logic [7:0]  load_ptr;
        logic [7:0]  dev;
        logic [7:0]  regad;
        logic [7:0]  len;
        bit          reading;
        int unsigned stage;
        bit          failed;
        t_res        pending[$];
        int          errors;

        function void reset_state();
            edge_hold = 8'd5;
            bit_half  = 8'd2;
            ack_limit = 16'd250;
            phase = PH_IDLE;
            ticks = 0;
            bits = 0;
            shreg = 0;
            byte_idx = 0;
            load_ptr = 0;
            dev = 0;
            regad = 0;
            len = 0;
            reading = 0;
            stage = 0;
            failed = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_EDGE_HOLD: edge_hold = val[7:0];
                CFG_BIT_PHASE: bit_half = val[7:0];
                CFG_ACK_TOUT:  ack_limit = val;
                default: ;
            endcase
        endfunction

        function void go(t_phase p);
            phase = p;
            ticks = 0;
        endfunction

        function void send(logic [7:0] v, int unsigned nxt);
            shreg = v;
            stage = nxt;
            bits = 0;
            go(PH_TX_LOW);
        endfunction

        function void next_data_byte();
            if (byte_idx < len) send(wbuf[byte_idx], 3);
            else go(PH_STOP_A);
        endfunction

        // Decide what follows a byte that the slave acknowledged.
        function void acked();
            case (stage)
                0: send(regad, 1);
                1: begin
                    if (reading) begin
                        shreg = dev + 8'd1;
                        stage = 2;
                        go(PH_START_A);
                    end else begin
                        next_data_byte();
                    end
                end
                2: begin
                    if (len == 0) go(PH_STOP_A);
                    else begin
                        bits = 0;
                        shreg = 0;
                        go(PH_RX_LOW);
                    end
                end
                default: begin
                    byte_idx = byte_idx + 8'd1;
                    next_data_byte();
                end
            endcase
        endfunction

        // Note one accepted tick and queue the result it must produce.
        function void note_tick(t_cmd cmd, logic [7:0] d, logic [7:0] r, logic [7:0] n,
                                logic [7:0] w, logic sda);
            int unsigned hold;
            int unsigned half;
            bit          mack;
            t_res        res;
            hold = (edge_hold == 0) ? 1 : edge_hold;
            half = (bit_half == 0) ? 1 : bit_half;
            res = '0;
            if (phase == PH_IDLE) begin
                if (cmd == CMD_LOAD) begin
                    wbuf[load_ptr] = w;
                    load_ptr = load_ptr + 8'd1;
                end else if (cmd == CMD_WRITE || cmd == CMD_READ) begin
                    dev = d;
                    regad = r;
                    len = n;
                    reading = (cmd == CMD_READ);
                    if (!reading) load_ptr = 0;
                    byte_idx = 0;
                    failed = 0;
                    shreg = d;
                    stage = 0;
                    go(PH_START_A);
                end
            end
            mack = ({24'd0, byte_idx} + 1 >= {24'd0, len});
            res.scl_level = 1;
            res.sda_level = 1;
            case (phase)
                PH_START_B: res.sda_level = 0;
                PH_TX_LOW: begin
                    res.scl_level = 0;
                    res.sda_level = shreg[7];
                end
                PH_TX_HIGH: res.sda_level = shreg[7];
                PH_ACK_REL, PH_RX_LOW: res.scl_level = 0;
                PH_MACK_LOW: begin
                    res.scl_level = 0;
                    res.sda_level = mack;
                end
                PH_MACK_HIGH: res.sda_level = mack;
                PH_STOP_A: begin
                    res.scl_level = 0;
                    res.sda_level = 0;
                end
                default: ;
            endcase
            case (phase)
                PH_START_A: if (++ticks >= hold) go(PH_START_B);
                PH_START_B: if (++ticks >= hold) begin
                    bits = 0;
                    go(PH_TX_LOW);
                end
                PH_TX_LOW: if (++ticks >= half) go(PH_TX_HIGH);
                PH_TX_HIGH: if (++ticks >= half) begin
                    shreg = shreg << 1;
                    bits++;
                    go(bits >= 8 ? PH_ACK_REL : PH_TX_LOW);
                end
                PH_ACK_REL: if (++ticks >= half) go(PH_ACK_WAIT);
                PH_ACK_WAIT: begin
                    if (sda == 0) acked();
                    else if (ticks >= ack_limit) begin
                        failed = 1;
                        go(PH_STOP_A);
                    end else ticks++;
                end
                PH_RX_LOW: if (++ticks >= half) go(PH_RX_HIGH);
                PH_RX_HIGH: begin
                    // Read bits are sampled on the first high tick only.
                    if (ticks == 0) begin
                        shreg = {shreg[6:0], sda};
                        bits++;
                        if (bits >= 8) begin
                            res.rdata = shreg;
                            res.rdata_valid = 1;
                        end
                    end
                    if (++ticks >= half) go(bits >= 8 ? PH_MACK_LOW : PH_RX_LOW);
                end
                PH_MACK_LOW: if (++ticks >= half) go(PH_MACK_HIGH);
                PH_MACK_HIGH: if (++ticks >= half) begin
                    byte_idx = byte_idx + 8'd1;
                    if (byte_idx < len) begin
                        bits = 0;
                        shreg = 0;
                        go(PH_RX_LOW);
                    end else go(PH_STOP_A);
                end
                PH_STOP_A: if (++ticks >= hold) go(PH_STOP_B);
                PH_STOP_B: if (++ticks >= hold) begin
                    res.done_res = 1;
                    res.status = failed;
                    res.result_count = failed ? 8'd0 : (reading ? len : 8'd1);
                    go(PH_IDLE);
                end
                default: ;
            endcase
            res.busy_res = (phase != PH_IDLE);
            pending.push_back(res);
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        endtask

        task check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.scl_level !== want.scl_level) report("scl", got.scl_level, want.scl_level);
            if (got.sda_level !== want.sda_level) report("sda", got.sda_level, want.sda_level);
            if (got.rdata !== want.rdata) report("rdata", got.rdata, want.rdata);
            if (got.rdata_valid !== want.rdata_valid)
                report("rdata_valid", got.rdata_valid, want.rdata_valid);
            if (got.busy_res !== want.busy_res) report("busy", got.busy_res, want.busy_res);
            if (got.done_res !== want.done_res) report("done", got.done_res, want.done_res);
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.result_count !== want.result_count)
                report("count", got.result_count, want.result_count);
        endtask
    endclass

    i2c_bus_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    bit bus_ack_low;    // When set, the emulated slave mostly drives SDA low, so bytes are usually acknowledged.
    int ticks_sent;

    localparam int QuietLimit = 200000;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor: result transfers are sampled at the clock edge, before the
    // nonblocking updates of that edge take effect. Input transfers are noted
    // by the driver at the edge that accepts them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result({o_scl_level, o_sda_level, o_rdata, o_rdata_valid,
                                 o_busy_res, o_done_res, o_status, o_result_count});
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // The receiver stalls at random; decided fresh on every edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one tick transfer, with a random gap before it. Valid stays high
    // after the transfer so that the next tick can follow without a gap.
    task send_tick(t_cmd cmd, logic [7:0] d, logic [7:0] r, logic [7:0] n,
                   logic [7:0] w, logic sda);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_dev_addr <= d;
        i_reg_addr <= r;
        i_byte_count <= n;
        i_wdata <= w;
        i_sda_in <= sda;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_tick(cmd, d, r, n, w, sda);
        ticks_sent++;
    endtask

    // A plain tick whose SDA level follows the emulated slave: mostly ACK,
    // random data bits; with acks disabled the line stays high.
    task bus_tick();
        logic sda;
        sda = bus_ack_low ? (($urandom_range(9) < 8) ? 1'b0 : 1'($urandom)) : 1'b1;
        send_tick(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), sda);
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [15:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Run one transaction to completion: load bytes for writes, start, then
    // tick until the engine reports idle in the predictor.
    task run_transaction(bit rd, logic [7:0] len, bit acks);
        bus_ack_low = acks;
        if (!rd) begin
            for (int k = 0; k < len; k++)
                send_tick(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'($urandom));
        end
        send_tick(rd ? CMD_READ : CMD_WRITE, 8'($urandom), 8'($urandom), len,
                  8'($urandom), 1'($urandom));
        while (sb.phase != PH_IDLE) bus_tick();
    endtask

    task random_phase(int n);
        int c;
        for (int k = 0; k < n; k++) begin
            c = $urandom_range(9);
            if (c < 7) run_transaction(1'($urandom_range(1)), 8'($urandom_range(3)),
                                       $urandom_range(9) != 0);
            else if (c == 7) begin
                // Commands sent while busy must be ignored.
                bus_ack_low = 1;
                send_tick(CMD_READ, 8'($urandom), 8'($urandom), 8'd1, 8'($urandom), 1'b0);
                repeat ($urandom_range(6)) send_tick(t_cmd'(2'($urandom)), 8'($urandom),
                                                     8'($urandom), 8'($urandom),
                                                     8'($urandom), 1'($urandom));
                while (sb.phase != PH_IDLE) bus_tick();
            end else send_tick(t_cmd'(2'($urandom_range(1))), 8'($urandom), 8'($urandom),
                               8'd0, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        send_idle_pct = 37;
        recv_idle_pct = 48;
        quiet_cycles = 0;
        ticks_sent = 0;
        bus_ack_low = 1;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_EDGE_HOLD;
        i_cfg_data = 0;
        i_valid = 0;
        i_cmd = CMD_TICK;
        i_dev_addr = 0;
        i_reg_addr = 0;
        i_byte_count = 0;
        i_wdata = 0;
        i_sda_in = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default timing, fast timing, zero length, timeouts, zero
        // registers and slower timing.
        run_transaction(0, 2, 1);
        run_transaction(1, 2, 1);
        write_reg(CFG_EDGE_HOLD, 16'd1);
        write_reg(CFG_BIT_PHASE, 16'd1);
        write_reg(CFG_ACK_TOUT, 16'd3);
        run_transaction(0, 0, 1);
        run_transaction(1, 0, 1);
        run_transaction(1, 1, 0);
        write_reg(CFG_ACK_TOUT, 16'd0);
        run_transaction(0, 1, 0);
        write_reg(CFG_ACK_TOUT, 16'hFFFF);
        send_tick(CMD_WRITE, 8'hFF, 8'h00, 8'd0, 8'hFF, 1'b0);
        while (sb.phase != PH_IDLE) bus_tick();
        send_tick(CMD_READ, 8'h00, 8'hFF, 8'd1, 8'h00, 1'b0);
        while (sb.phase != PH_IDLE) bus_tick();
        write_reg(CFG_EDGE_HOLD, 16'd0);
        write_reg(CFG_BIT_PHASE, 16'd0);
        run_transaction(1, 2, 1);
        write_reg(CFG_ACK_TOUT, 16'd2);
        write_reg(CFG_EDGE_HOLD, 16'd2);
        write_reg(CFG_BIT_PHASE, 16'd2);
        run_transaction(1, 1, 1);
        run_transaction(0, 1, 0);

        // A longer write with data bytes taken back to back from the buffer.
        write_reg(CFG_EDGE_HOLD, 16'd1);
        write_reg(CFG_BIT_PHASE, 16'd1);
        run_transaction(0, 8'd4, 1);

        // Random phases with changing idling and timing.
        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                send_idle_pct = 48;
                recv_idle_pct = 37;
            end else if (p == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_EDGE_HOLD, 16'($urandom_range(1, 3)));
            write_reg(CFG_BIT_PHASE, 16'($urandom_range(1, 2)));
            write_reg(CFG_ACK_TOUT, 16'($urandom_range(0, 4)));
            random_phase(1);
        end
        while (ticks_sent < 1050) random_phase(1);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
